// ===== rtl/core/cset_pkg.sv =====
// Shared types, constants and id helpers for the call stack exclusive time core.
// Used by call_stack_exclusive_time_core; no dependencies.
package cset_pkg;

  localparam int NUM_FUNCS   = 64;
  localparam int STACK_DEPTH = 64;

  localparam int ID_W   = 6;
  localparam int TS_W   = 32;
  localparam int TOT_W  = 32;
  localparam int REQ_W  = 2;
  localparam int STS_W  = 2;

  localparam int FA_W   = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = (FA_W > ID_W) ? FA_W : ID_W;
  localparam int STK_W  = ID_W + TS_W;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [STS_W-1:0] sts_t;

  localparam req_t REQ_START = 2'd0;
  localparam req_t REQ_END   = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  localparam sts_t STS_OK    = 2'd0;
  localparam sts_t STS_OVF   = 2'd1;
  localparam sts_t STS_EMPTY = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIN  = 5'b00010,
    S_POP1 = 5'b00100,
    S_POP2 = 5'b01000,
    S_POP3 = 5'b10000
  } state_t;

  // Totals memory address of a function id.
  function automatic logic [FA_W-1:0] fid_addr(logic [ID_W-1:0] id);
    logic [IDX_W-1:0] x;
    x = IDX_W'(id);
    return x[FA_W-1:0];
  endfunction

  // Ids at or above NUM_FUNCS have no total.
  function automatic logic fid_ok(logic [ID_W-1:0] id);
    logic [IDX_W:0] x;
    x = (IDX_W + 1)'(id);
    return x < (IDX_W + 1)'(NUM_FUNCS);
  endfunction

endpackage

// ===== rtl/core/cset_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module cset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/call_stack_exclusive_time_core.sv =====
// Call stack exclusive time core: call stack RAM, totals RAM and the event sequencer.
// Depends on cset_pkg and cset_ram.
//
// Usage:
//   Input words (in_req_type, in_func_id, in_timestamp) are taken when in_valid is high
//   and in_stall is low. Every input word yields exactly one result word
//   (out_status, out_result_id, out_total_time), held while out_stall is high.
//   A start pushes the id and timestamp; an end pops the top entry, adds the
//   inclusive span to the popped id and subtracts it from the caller; a read
//   (or request code 3) reports one total. Overflow and empty-stack errors
//   change no state.
// Sequencing:
//   Start and read: result word registered at the end of S_FIN, the state after acceptance.
//   End: steps S_POP1, S_POP2 and S_POP3 (span, popped-total update, caller-total
//   update, with the stack read issued at acceptance), all through one shared 32-bit
//   adder and one read port per RAM. The next word is taken once the core is
//   back in idle and the result register is free or draining.
// Reset:
//   rst_n low clears the stack pointer, all totals (per-entry valid bits) and
//   the result valid flag. No clearing pass is needed.
module call_stack_exclusive_time_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cset_pkg::REQ_W-1:0]  in_req_type,
  input  logic [cset_pkg::ID_W-1:0]   in_func_id,
  input  logic [cset_pkg::TS_W-1:0]   in_timestamp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cset_pkg::STS_W-1:0]  out_status,
  output logic [cset_pkg::ID_W-1:0]   out_result_id,
  output logic signed [cset_pkg::TOT_W-1:0] out_total_time
);
  import cset_pkg::*;

  state_t            state_r, state_nxt;
  logic [SP_W-1:0]   count_r, count_nxt;
  logic [NUM_FUNCS-1:0] tot_vld_r, tot_vld_nxt;
  logic [FA_W-1:0]   tq_r, tq_nxt;

  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic [STS_W-1:0]  sts_r, sts_nxt;
  logic [TOT_W-1:0]  span_r, span_nxt;
  logic [TOT_W-1:0]  pop_tot_r, pop_tot_nxt;
  logic [ID_W-1:0]   caller_id_r, caller_id_nxt;
  logic              has_caller_r, has_caller_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]  out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_result_id_r, out_result_id_nxt;
  logic [TOT_W-1:0]  out_total_time_r, out_total_time_nxt;

  // stack RAM
  logic              stk_we;
  logic [SA_W-1:0]   stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_rdata;
  logic [ID_W-1:0]   stk_rid;
  logic [TS_W-1:0]   stk_rts;

  // totals RAM
  logic              tot_we;
  logic [FA_W-1:0]   tot_waddr, tot_raddr;
  logic [TOT_W-1:0]  tot_wdata, tot_rdata, tot_rd_val;

  // shared adder
  logic [TOT_W-1:0]  alu_a, alu_b, alu_y;
  logic [1:0]        alu_c;

  logic              accept, out_free, same_id;
  logic [SP_W-1:0]   cnt_m1, cnt_m2;

  cset_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  cset_ram #(.WIDTH(TOT_W), .DEPTH(NUM_FUNCS)) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  assign stk_rid = stk_rdata[STK_W-1 -: ID_W];
  assign stk_rts = stk_rdata[TS_W-1:0];

  assign tot_rd_val = tot_vld_r[tq_r] ? tot_rdata : '0;
  assign alu_y      = alu_a + alu_b + TOT_W'(alu_c);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign cnt_m1  = count_r - SP_W'(1);
  assign cnt_m2  = count_r - SP_W'(2);
  assign same_id = (caller_id_r == rid_r);

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_result_id  = out_result_id_r;
  assign out_total_time = out_total_time_r;

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    tot_vld_nxt        = tot_vld_r;
    tq_nxt             = tq_r;
    ts_nxt             = ts_r;
    rid_nxt            = rid_r;
    sts_nxt            = sts_r;
    span_nxt           = span_r;
    pop_tot_nxt        = pop_tot_r;
    caller_id_nxt      = caller_id_r;
    has_caller_nxt     = has_caller_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_status_nxt     = out_status_r;
    out_result_id_nxt  = out_result_id_r;
    out_total_time_nxt = out_total_time_r;

    stk_we    = 1'b0;
    stk_waddr = count_r[SA_W-1:0];
    stk_wdata = {in_func_id, in_timestamp};
    stk_raddr = cnt_m1[SA_W-1:0];
    tot_we    = 1'b0;
    tot_waddr = fid_addr(rid_r);
    tot_wdata = alu_y;
    tot_raddr = fid_addr(in_func_id);

    alu_a = ts_r;
    alu_b = ~stk_rts;
    alu_c = 2'd2;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ts_nxt  = in_timestamp;
          rid_nxt = in_func_id;
          sts_nxt = STS_OK;
          tq_nxt  = fid_addr(in_func_id);
          priority if (in_req_type == REQ_START) begin
            if (count_r == SP_W'(STACK_DEPTH)) begin
              sts_nxt = STS_OVF;
            end else begin
              stk_we    = 1'b1;
              count_nxt = count_r + SP_W'(1);
            end
            state_nxt = S_FIN;
          end else if (in_req_type == REQ_END) begin
            if (count_r == '0) begin
              sts_nxt   = STS_EMPTY;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_POP1;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        out_valid_nxt      = 1'b1;
        out_status_nxt     = sts_r;
        out_result_id_nxt  = rid_r;
        out_total_time_nxt = fid_ok(rid_r) ? tot_rd_val : '0;
        state_nxt          = S_IDLE;
      end
      S_POP1: begin
        // span = ts - start + 1
        span_nxt       = alu_y;
        rid_nxt        = stk_rid;
        tot_raddr      = fid_addr(stk_rid);
        tq_nxt         = fid_addr(stk_rid);
        stk_raddr      = cnt_m2[SA_W-1:0];
        has_caller_nxt = (count_r >= SP_W'(2));
        count_nxt      = cnt_m1;
        state_nxt      = S_POP2;
      end
      S_POP2: begin
        alu_a         = tot_rd_val;
        alu_b         = span_r;
        alu_c         = 2'd0;
        tot_we        = fid_ok(rid_r);
        tot_waddr     = fid_addr(rid_r);
        pop_tot_nxt   = alu_y;
        if (fid_ok(rid_r)) begin
          tot_vld_nxt[fid_addr(rid_r)] = 1'b1;
        end
        caller_id_nxt = stk_rid;
        tot_raddr     = fid_addr(stk_rid);
        tq_nxt        = fid_addr(stk_rid);
        state_nxt     = S_POP3;
      end
      S_POP3: begin
        // recursive call: the caller's total was just updated above
        alu_a     = same_id ? pop_tot_r : tot_rd_val;
        alu_b     = ~span_r;
        alu_c     = 2'd1;
        tot_we    = has_caller_r && fid_ok(caller_id_r);
        tot_waddr = fid_addr(caller_id_r);
        if (has_caller_r && fid_ok(caller_id_r)) begin
          tot_vld_nxt[fid_addr(caller_id_r)] = 1'b1;
        end
        out_valid_nxt     = 1'b1;
        out_status_nxt    = STS_OK;
        out_result_id_nxt = rid_r;
        if (!fid_ok(rid_r)) begin
          out_total_time_nxt = '0;
        end else if (has_caller_r && same_id) begin
          out_total_time_nxt = alu_y;
        end else begin
          out_total_time_nxt = pop_tot_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tot_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tot_vld_r   <= tot_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tq_r             <= tq_nxt;
    ts_r             <= ts_nxt;
    rid_r            <= rid_nxt;
    sts_r            <= sts_nxt;
    span_r           <= span_nxt;
    pop_tot_r        <= pop_tot_nxt;
    caller_id_r      <= caller_id_nxt;
    has_caller_r     <= has_caller_nxt;
    out_status_r     <= out_status_nxt;
    out_result_id_r  <= out_result_id_nxt;
    out_total_time_r <= out_total_time_nxt;
  end

endmodule
